/* rtl/bda_pkg.sv */
// shared types and constants for the binary to decimal ascii converter
package bda_pkg;

    localparam int BIN_WIDTH  = 32;
    localparam int DIGITS     = 10;
    localparam int STEP_W     = $clog2(BIN_WIDTH);
    localparam int DIG_IDX_W  = $clog2(DIGITS);
    localparam int CHAR_WIDTH = 6;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

    typedef logic [3:0]              digit_t;
    typedef logic [DIGITS-1:0][3:0]  bcd_t;
    typedef logic [BIN_WIDTH-1:0]    bin_t;
    typedef logic [STEP_W-1:0]       step_t;
    typedef logic [DIG_IDX_W-1:0]    dig_idx_t;
    typedef logic [CHAR_WIDTH-1:0]   char_t;

endpackage

/* rtl/binary_to_decimal_ascii.sv */
// top level: sequencer around the shared shift-add-3 unit and the digit emitter
//
//  channel   | handshake              | fields
//  ----------+------------------------+------------------
//  request   | start, busy            | value
//  result    | strobe (no back-pressure) | digit_char, last
//
// a request is taken when start is high and busy is low:
// one shift-add-3 step per value bit through the one shared unit, then sizing of the number,
// then one character per cycle, most significant first, one to ten characters in all
// results appear in the cycle after their emit cycle, so the last strobe may overlap idle
// reset clears the sequencer and the strobe; the receiver cannot stall the block
module binary_to_decimal_ascii (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bda_pkg::bin_t         value,
    output logic                  busy,
    output logic                  strobe,
    output bda_pkg::char_t        digit_char,
    output logic                  last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_SIZE,
        S_EMIT
    } state_t;

    state_t            state_reg,  state_next;
    bda_pkg::bin_t     bin_reg,    bin_next;
    bda_pkg::bcd_t     bcd_reg,    bcd_next;
    bda_pkg::step_t    step_reg,   step_next;
    bda_pkg::dig_idx_t idx_reg,    idx_next;
    logic              strobe_reg, strobe_next;
    bda_pkg::char_t    char_reg,   char_next;
    logic              last_reg,   last_next;

    bda_pkg::bcd_t     bcd_step;
    bda_pkg::dig_idx_t top_idx;

    bda_shift_add3 u_step (
        .bcd_in  (bcd_reg),
        .bit_in  (bin_reg[bda_pkg::BIN_WIDTH-1]),
        .bcd_out (bcd_step)
    );

    // highest non-zero digit, zero gives a single digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < bda_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = bda_pkg::dig_idx_t'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    bin_next   = value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = S_CONVERT;
                end
            end
            S_CONVERT:
            begin
                bcd_next  = bcd_step;
                bin_next  = bin_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == bda_pkg::step_t'(bda_pkg::BIN_WIDTH - 1))
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                idx_next   = top_idx;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = bda_pkg::ASCII_ZERO + {2'b00, bcd_reg[idx_reg]};
                last_next   = (idx_reg == '0);
                idx_next    = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            bin_reg    <= '0;
            bcd_reg    <= '0;
            step_reg   <= '0;
            idx_reg    <= '0;
            char_reg   <= bda_pkg::ASCII_ZERO;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            bin_reg    <= bin_next;
            bcd_reg    <= bcd_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit_char >= bda_pkg::ASCII_ZERO) &&
                   (digit_char <= bda_pkg::ASCII_ZERO + 6'd9))
        else $error("result character is not a decimal digit");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character emitted after the last one of a run");

    a_no_result_in_convert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONVERT) |=> !strobe)
        else $error("result emitted during conversion");
`endif

endmodule

/* rtl/bda_shift_add3.sv */
// one double dabble step: add three to every digit above four, then shift in a bit
module bda_shift_add3 (
    input  bda_pkg::bcd_t bcd_in,
    input  logic          bit_in,
    output bda_pkg::bcd_t bcd_out
);

    bda_pkg::bcd_t adj;

    always_comb
    begin
        for (int i = 0; i < bda_pkg::DIGITS; i++)
        begin
            if (bcd_in[i] >= 4'd5)
            begin
                adj[i] = bcd_in[i] + 4'd3;
            end
            else
            begin
                adj[i] = bcd_in[i];
            end
        end
    end

    assign bcd_out = bda_pkg::bcd_t'({adj, bit_in});

endmodule
